FILE: src/gb5_pkg.sv
`default_nettype none

package gb5_pkg;

  // Pixel and window geometry
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned GROUP_LEN   = 5;
  localparam int unsigned ROWS        = 5;
  localparam int unsigned COUNT_W     = 3;
  localparam logic [COUNT_W-1:0] GROUP_LAST = COUNT_W'(GROUP_LEN - 1);

  // Gray conversion: floor(s / 3) = (s * 683) >> 11 for s <= 765
  localparam int unsigned CSUM_W      = 10;
  localparam int unsigned DIV3_SHIFT  = 11;
  localparam logic [CSUM_W-1:0] DIV3_MUL = CSUM_W'(683);
  localparam int unsigned DIV3_PROD_W = 2 * CSUM_W;

  // Kernel weights, row-major, sum 273
  localparam int unsigned WEIGHT_W = 6;
  localparam logic [WEIGHT_W-1:0] KERNEL [ROWS*GROUP_LEN] = '{
    6'd1,  6'd4,  6'd7,  6'd4,  6'd1,
    6'd4,  6'd16, 6'd26, 6'd16, 6'd4,
    6'd7,  6'd26, 6'd41, 6'd26, 6'd7,
    6'd4,  6'd16, 6'd26, 6'd16, 6'd4,
    6'd1,  6'd4,  6'd7,  6'd4,  6'd1
  };

  // Sum widths: one row stays below 2^15, the window below 2^17
  localparam int unsigned ROWSUM_W = 15;
  localparam int unsigned TOTAL_W  = 17;

  // floor(x / 273) = (x * 122911) >> 25 for x <= 69615
  localparam int unsigned DIV273_SHIFT  = 25;
  localparam logic [TOTAL_W-1:0] DIV273_MUL = TOTAL_W'(122911);
  localparam int unsigned DIV273_PROD_W = 2 * TOTAL_W;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One finished group of five gray pixels, index = column
  typedef logic [GROUP_LEN-1:0][PIX_W-1:0] group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

FILE: src/gb5_front.sv
`default_nettype none

module gb5_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            red,
  input  wire logic [7:0]            green,
  input  wire logic [7:0]            blue,
  input  wire gb5_pkg::queue_status_t q_status,
  output logic                       push,
  output gb5_pkg::group_t            push_data
);

  logic [gb5_pkg::COUNT_W-1:0]       group_count;
  logic [gb5_pkg::GROUP_LEN-2:0][gb5_pkg::PIX_W-1:0] gray_buf;
  logic [gb5_pkg::CSUM_W-1:0]        chan_sum;
  logic [gb5_pkg::DIV3_PROD_W-1:0]   div3_prod;
  logic [gb5_pkg::PIX_W-1:0]         gray;
  logic                              accept;
  logic                              last;

  // Convert to gray with a reciprocal multiply
  assign chan_sum  = gb5_pkg::CSUM_W'(red) + gb5_pkg::CSUM_W'(green)
                   + gb5_pkg::CSUM_W'(blue);
  assign div3_prod = gb5_pkg::DIV3_PROD_W'(chan_sum)
                   * gb5_pkg::DIV3_PROD_W'(gb5_pkg::DIV3_MUL);
  assign gray      = div3_prod[gb5_pkg::DIV3_SHIFT +: gb5_pkg::PIX_W];

  // Hold only the last beat of a group when the queue is full
  assign last     = (group_count == gb5_pkg::GROUP_LAST);
  assign in_stall = last && q_status.full;
  assign accept   = in_valid && !in_stall;

  // Push the finished group on its last beat
  assign push = accept && last;
  always_comb begin
    for (int i = 0; i < gb5_pkg::GROUP_LEN - 1; i++) begin
      push_data[i] = gray_buf[i];
    end
    push_data[gb5_pkg::GROUP_LEN-1] = gray;
  end

  // Collect gray pixels and advance the group count
  always_ff @(posedge clk) begin
    if (rst) begin
      group_count <= '0;
    end else if (accept) begin
      if (last) begin
        group_count <= '0;
      end else begin
        group_count <= group_count + gb5_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !last) begin
      gray_buf[group_count[gb5_pkg::COUNT_W-2:0]] <= gray;
    end
  end

  a_stall_only_on_last: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> group_count == gb5_pkg::GROUP_LAST)
    else $error("front stalls outside the last beat of a group");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    group_count <= gb5_pkg::GROUP_LAST)
    else $error("group count out of range");

endmodule

`default_nettype wire

FILE: src/gb5_queue.sv
`default_nettype none

module gb5_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire gb5_pkg::group_t        push_data,
  input  wire logic                   pop,
  output gb5_pkg::group_t             pop_data,
  output gb5_pkg::queue_status_t      status
);

  gb5_pkg::group_t                    slots [gb5_pkg::QUEUE_DEPTH];
  logic [gb5_pkg::QUEUE_PTR_W-1:0]    wr_ptr;
  logic [gb5_pkg::QUEUE_PTR_W-1:0]    rd_ptr;
  logic [gb5_pkg::QUEUE_CNT_W-1:0]    count;

  assign status.full  = (count == gb5_pkg::QUEUE_CNT_W'(gb5_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign pop_data     = slots[rd_ptr];

  function automatic logic [gb5_pkg::QUEUE_PTR_W-1:0] ptr_inc(
    input logic [gb5_pkg::QUEUE_PTR_W-1:0] ptr
  );
    if (ptr == gb5_pkg::QUEUE_PTR_W'(gb5_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return ptr + gb5_pkg::QUEUE_PTR_W'(1);
  endfunction

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({push, pop})
        2'b10:   count <= count + gb5_pkg::QUEUE_CNT_W'(1);
        2'b01:   count <= count - gb5_pkg::QUEUE_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && status.empty))
    else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: src/gb5_back.sv
`default_nettype none

module gb5_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire gb5_pkg::queue_status_t q_status,
  input  wire gb5_pkg::group_t        pop_data,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [7:0]                  blurred
);

  gb5_pkg::group_t                    win [gb5_pkg::ROWS];
  logic [gb5_pkg::ROWSUM_W-1:0]       row_sum [gb5_pkg::ROWS];
  logic [gb5_pkg::ROWSUM_W-1:0]       row_sum_next [gb5_pkg::ROWS];
  logic [gb5_pkg::TOTAL_W-1:0]        total;
  logic [gb5_pkg::TOTAL_W-1:0]        total_next;
  logic [gb5_pkg::DIV273_PROD_W-1:0]  div_prod;
  logic                               win_valid;
  logic                               row_valid;
  logic                               total_valid;
  logic                               advance;

  // Move the whole pipe whenever the output register can take a beat
  assign advance = !out_valid || !out_stall;
  assign pop     = advance && !q_status.empty;

  // Shift the window up one row and load the new group at the bottom
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < gb5_pkg::ROWS; r++) begin
        win[r] <= '0;
      end
    end else if (pop) begin
      for (int r = 0; r < gb5_pkg::ROWS - 1; r++) begin
        win[r] <= win[r+1];
      end
      win[gb5_pkg::ROWS-1] <= pop_data;
    end
  end

  // Weight each row with constant coefficients
  always_comb begin
    for (int r = 0; r < gb5_pkg::ROWS; r++) begin
      row_sum_next[r] = '0;
      for (int c = 0; c < gb5_pkg::GROUP_LEN; c++) begin
        row_sum_next[r] = row_sum_next[r]
          + gb5_pkg::ROWSUM_W'(win[r][c])
          * gb5_pkg::ROWSUM_W'(gb5_pkg::KERNEL[r*gb5_pkg::GROUP_LEN + c]);
      end
    end
  end

  // Add the row sums
  always_comb begin
    total_next = '0;
    for (int r = 0; r < gb5_pkg::ROWS; r++) begin
      total_next = total_next + gb5_pkg::TOTAL_W'(row_sum[r]);
    end
  end

  // Divide by 273 with a reciprocal multiply
  assign div_prod = gb5_pkg::DIV273_PROD_W'(total)
                  * gb5_pkg::DIV273_PROD_W'(gb5_pkg::DIV273_MUL);

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid   <= 1'b0;
      row_valid   <= 1'b0;
      total_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else if (advance) begin
      win_valid   <= pop;
      row_valid   <= win_valid;
      total_valid <= row_valid;
      out_valid   <= total_valid;
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int r = 0; r < gb5_pkg::ROWS; r++) begin
        row_sum[r] <= row_sum_next[r];
      end
      total   <= total_next;
      blurred <= div_prod[gb5_pkg::DIV273_SHIFT +: 8];
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    total_valid && advance |=> out_valid)
    else $error("finished sum did not reach the output register");

endmodule

`default_nettype wire

FILE: src/gaussian_blur_5x5_gray_unit.sv
// Channel  Direction  Handshake              Payload
// pixel    in         in_valid / in_stall    red, green, blue (8 bits each)
// result   out        out_valid / out_stall  blurred (8 bits)
//
// One pixel is taken per cycle while in_stall is low; every fifth pixel yields one result.
// After the fifth pixel of its group is taken, a result passes the registered steps
// queue read, row weighting, row add and divide by 273, in that order.
// in_stall rises only on the fifth pixel of a group while the two-entry group
// queue is full; out_stall with out_valid high freezes the whole back pipeline.
// Synchronous reset clears the window to zero, the group count, the queue and the stage valids.
`default_nettype none

module gaussian_blur_5x5_gray_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] red,
  input  wire logic [7:0] green,
  input  wire logic [7:0] blue,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      blurred
);

  gb5_pkg::queue_status_t q_status;
  gb5_pkg::group_t        push_data;
  gb5_pkg::group_t        pop_data;
  logic                   push;
  logic                   pop;

  gb5_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  gb5_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  gb5_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .blurred   (blurred)
  );

endmodule

`default_nettype wire

FILE: tb/sv/gaussian_blur_5x5_gray_unit_checker.sv
module gaussian_blur_5x5_gray_unit_checker (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic                      in_stall,
  input  wire logic [gb5_pkg::PIX_W-1:0] red,
  input  wire logic [gb5_pkg::PIX_W-1:0] green,
  input  wire logic [gb5_pkg::PIX_W-1:0] blue,
  input  wire logic                      out_valid,
  input  wire logic                      out_stall,
  input  wire logic [gb5_pkg::PIX_W-1:0] blurred,
  output int                             mismatches,
  output int                             results_owed
);

  localparam int unsigned WINDOW_LEN = 25;
  localparam int unsigned ROW_LEN    = 5;
  localparam int unsigned LAST_COL   = ROW_LEN - 1;
  localparam int unsigned WEIGHT_SUM = 273;

  // 5x5 Gaussian weights, row-major, summing to WEIGHT_SUM
  localparam int unsigned BLUR_WEIGHT [WINDOW_LEN] = '{
    1,  4,  7,  4, 1,
    4, 16, 26, 16, 4,
    7, 26, 41, 26, 7,
    4, 16, 26, 16, 4,
    1,  4,  7,  4, 1
  };

  logic [gb5_pkg::PIX_W-1:0] gray_window [WINDOW_LEN];
  int unsigned               pixels_in_group;
  logic [gb5_pkg::PIX_W-1:0] expected_blur [$];
  int                        error_total = 0;

  always @(posedge clk) begin
    int unsigned               gray;
    int unsigned               acc;
    logic [gb5_pkg::PIX_W-1:0] want;
    if (rst) begin
      // Clear the window, the group position and the pending predictions
      foreach (gray_window[k]) gray_window[k] = '0;
      pixels_in_group = 0;
      expected_blur.delete();
    end else begin
      // Compare a result beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_blur.size() == 0) begin
          $display("%0t: blurred mismatch: expected no beat, actual %0d", $time, blurred);
          error_total++;
        end else begin
          want = expected_blur.pop_front();
          if (blurred !== want) begin
            $display("%0t: blurred mismatch: expected %0d, actual %0d",
                     $time, want, blurred);
            error_total++;
          end
        end
      end

      // Advance the window on a pixel beat
      if (in_valid && !in_stall) begin
        gray = (32'(red) + 32'(green) + 32'(blue)) / 3;
        if (pixels_in_group == 0) begin
          for (int k = 0; k < WINDOW_LEN - ROW_LEN; k++) gray_window[k] = gray_window[k + ROW_LEN];
        end
        gray_window[WINDOW_LEN - ROW_LEN + pixels_in_group] = gb5_pkg::PIX_W'(gray);
        if (pixels_in_group == LAST_COL) begin
          acc = 0;
          for (int k = 0; k < WINDOW_LEN; k++) acc += BLUR_WEIGHT[k] * gray_window[k];
          expected_blur.push_back(gb5_pkg::PIX_W'(acc / WEIGHT_SUM));
          pixels_in_group = 0;
        end else begin
          pixels_in_group++;
        end
      end
    end
    mismatches   <= error_total;
    results_owed <= expected_blur.size();
  end

endmodule

FILE: tb/sv/gaussian_blur_5x5_gray_unit_tb.sv
module gaussian_blur_5x5_gray_unit_tb;

  localparam int unsigned RANDOM_PIXELS = 850;
  localparam int unsigned DRAIN_EVERY   = 300;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned TAIL_CYCLES   = 20;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       out_stall = 1'b0;
  logic [7:0] red       = '0;
  logic [7:0] green     = '0;
  logic [7:0] blue      = '0;
  wire logic       in_stall;
  wire logic       out_valid;
  wire logic [7:0] blurred;

  int mismatches;
  int results_owed;
  int idle_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  gaussian_blur_5x5_gray_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .blurred   (blurred)
  );

  gaussian_blur_5x5_gray_unit_checker blur_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .blurred      (blurred),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  // Stall the result side in phases: free, light, even, heavy
  int stall_phase = 0;
  int phase_left  = 0;
  always @(negedge clk) begin
    if (phase_left == 0) begin
      stall_phase = $urandom_range(0, 3);
      phase_left  = $urandom_range(20, 120);
    end else begin
      phase_left--;
    end
    case (stall_phase)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // End the run if no beat moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** gaussian_blur_5x5_gray_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one pixel beat from a falling edge and hold it until taken
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    in_valid <= 1'b1;
    red      <= r;
    green    <= g;
    blue     <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Hold off the pixel side until every predicted result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    @(negedge clk);
  endtask

  initial begin
    int unsigned burst_left;
    int unsigned scene_kind;
    int unsigned scene_left;
    logic [7:0]  level;
    logic [7:0]  r, g, b;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Window still partly zero from reset: one white group, then black
    repeat (5) send_pixel(8'hFF, 8'hFF, 8'hFF);
    repeat (5) send_pixel(8'h00, 8'h00, 8'h00);
    // Opposite bit patterns across the channels
    send_pixel(8'hAA, 8'h55, 8'hFF);
    send_pixel(8'h55, 8'hAA, 8'h00);
    send_pixel(8'h0F, 8'hF0, 8'h81);
    send_pixel(8'hF0, 8'h0F, 8'h7E);
    send_pixel(8'h80, 8'h01, 8'hC3);
    // Channel sums just off a multiple of three, truncated on the divide
    send_pixel(8'hFF, 8'hFF, 8'hFE);
    send_pixel(8'h01, 8'h00, 8'h00);
    send_pixel(8'h01, 8'h01, 8'h00);
    send_pixel(8'h02, 8'h02, 8'h01);
    send_pixel(8'hFE, 8'hFE, 8'hFF);
    // Bright group after a mixed window
    repeat (5) send_pixel(8'hFF, 8'hFF, 8'hFF);
    wait_drained();

    // Random scenes of varying texture, sent in bursts
    burst_left = 0;
    scene_left = 0;
    scene_kind = 0;
    level      = '0;
    for (int unsigned sent = 0; sent < RANDOM_PIXELS; sent++) begin
      if (sent % DRAIN_EVERY == DRAIN_EVERY - 1) wait_drained();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(negedge clk);
        end
      end
      burst_left--;
      if (scene_left == 0) begin
        scene_kind = $urandom_range(0, 3);
        scene_left = $urandom_range(10, 60);
        level      = 8'($urandom_range(0, 255));
      end
      scene_left--;
      case (scene_kind)
        0: begin
          r = 8'($urandom_range(0, 255));
          g = 8'($urandom_range(0, 255));
          b = 8'($urandom_range(0, 255));
        end
        1: begin
          r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        2: begin
          r = 8'hFF;
          g = 8'hFF;
          b = 8'hFF;
        end
        default: begin
          r = level ^ 8'($urandom_range(0, 3));
          g = level ^ 8'($urandom_range(0, 3));
          b = level ^ 8'($urandom_range(0, 3));
        end
      endcase
      send_pixel(r, g, b);
    end

    // Drain and let the pipeline settle before the verdict
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** gaussian_blur_5x5_gray_unit: PASSED **");
    end else begin
      $display("** gaussian_blur_5x5_gray_unit: FAILED **");
    end
    $finish;
  end

endmodule
